FILE: hdl/ffpm_pkg.sv
package ffpm_pkg;

  localparam int MaxPalettes = 8;
  localparam int MaxColors   = 4;
  localparam int TileSlots   = 4;
  localparam int ColorW      = 32;
  localparam int CfgW        = 3;
  localparam int InCntW      = 3;
  localparam int IdxOutW     = 3;

  localparam int PalIdxW = (MaxPalettes > 1) ? $clog2(MaxPalettes) : 1;
  localparam int UsedW   = $clog2(MaxPalettes + 1);
  localparam int SlotW   = (MaxColors > 1) ? $clog2(MaxColors) : 1;
  localparam int CntW    = $clog2(MaxColors + 1);
  localparam int TileCntW = $clog2(TileSlots + 1);

  localparam logic [CfgW-1:0] CfgReset = CfgW'(4);

  typedef enum logic [1:0] {
    StMerged  = 2'd0,
    StNew     = 2'd1,
    StTooMany = 2'd2,
    StFull    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SIdle,
    SScan,
    SPlace,
    SDone
  } state_e;

  typedef logic [TileSlots-1:0][ColorW-1:0] tile_t;

  // One sub-palette: its colors and how many are in use.
  typedef struct packed {
    logic [MaxColors-1:0][ColorW-1:0] colors;
    logic [CntW-1:0]                  size;
  } row_t;

  // Appends the masked tile colors, in order, behind the first start slots.
  function automatic row_t append_colors(row_t base, logic [CntW-1:0] start,
                                         logic [TileSlots-1:0] mask, tile_t tile);
    row_t            r;
    logic [CntW-1:0] pos;
    r   = base;
    pos = start;
    for (int i = 0; i < TileSlots; i++) begin
      if (mask[i] && (int'(pos) < MaxColors)) begin
        r.colors[pos[SlotW-1:0]] = tile[i];
        pos = pos + CntW'(1);
      end
    end
    r.size = pos;
    return r;
  endfunction

endpackage

FILE: hdl/first_fit_palette_merge.sv
// First-fit sub-palette packer.
// Input channel (in_valid_i / in_stall_o): one beat carries a tile's color
// set, color_count_i plus color_0_i..color_3_i; duplicates count once.
// Output channel (out_valid_o / out_stall_i): one beat per input beat with
// palette_index_o and status_o (merged, new entry, too many colors, full).
// cfg_we_i / cfg_data_i write colors_per_palette; write it only while idle.
// The sub-palettes live in one row-wide synchronous RAM (one row per entry,
// size kept in the row), read one row per cycle during the scan.
// A rejected tile goes straight to the done state and its result to the
// output register; otherwise the scan reads the entries in order from 0
// until one fits; a tile that fits none gets a new entry or status full.
// One tile is worked on at a time; the next beat is taken as soon as the
// result is in the output register, even while that result is stalled.
// A result that cannot enter a stalled output register holds the engine.
// Reset empties the table (entry count to zero, no RAM sweep needed) and
// sets colors_per_palette to 4.
module first_fit_palette_merge
  import ffpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [InCntW-1:0]    color_count_i,
  input  logic [ColorW-1:0]    color_0_i,
  input  logic [ColorW-1:0]    color_1_i,
  input  logic [ColorW-1:0]    color_2_i,
  input  logic [ColorW-1:0]    color_3_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IdxOutW-1:0]   palette_index_o,
  output logic [1:0]           status_o
);

  row_t                 mem [MaxPalettes];
  row_t                 rdata_q;
  logic [PalIdxW-1:0]   rd_addr;
  logic                 mem_we;
  logic [PalIdxW-1:0]   wr_addr;
  row_t                 wr_row;
  logic                 wr_new;

  state_e               state_q, state_d;
  logic [CfgW-1:0]      cfg_q;
  logic [UsedW-1:0]     used_q, used_d;
  logic [PalIdxW-1:0]   chk_q, chk_d;
  tile_t                tile_q;
  logic [TileSlots-1:0] mask_q;
  logic [CntW-1:0]      n_q;
  logic [IdxOutW-1:0]   res_idx_q, res_idx_d;
  status_e              res_st_q, res_st_d;
  logic                 out_valid_q;
  logic [IdxOutW-1:0]   out_idx_q;
  status_e              out_st_q;

  logic [CntW-1:0]      limit;
  tile_t                tile_in;
  logic [TileSlots-1:0] mask_in;
  logic [TileCntW-1:0]  n_in;
  logic                 accept, reject_in, out_load;
  logic [TileSlots-1:0] has, extra_mask;
  logic [CntW:0]        grown;
  logic                 fit, last_entry, full;

  assign limit = (int'(cfg_q) > MaxColors) ? CntW'(MaxColors) : CntW'(cfg_q);

  assign tile_in = {color_3_i, color_2_i, color_1_i, color_0_i};

  // First valid occurrence of each distinct color.
  always_comb begin
    for (int i = 0; i < TileSlots; i++) begin
      mask_in[i] = (i < int'(color_count_i));
      for (int j = 0; j < i; j++) begin
        if (tile_in[j] == tile_in[i]) mask_in[i] = 1'b0;
      end
    end
  end

  assign n_in      = TileCntW'($countones(mask_in));
  assign reject_in = (int'(color_count_i) > TileSlots) || (int'(n_in) > int'(limit));
  assign in_stall_o = (state_q != SIdle);
  assign accept     = in_valid_i && !in_stall_o;

  // Membership of the tile colors in the row just read.
  always_comb begin
    for (int i = 0; i < TileSlots; i++) begin
      has[i] = 1'b0;
      for (int k = 0; k < MaxColors; k++) begin
        if ((k < int'(rdata_q.size)) && (rdata_q.colors[k] == tile_q[i])) has[i] = 1'b1;
      end
    end
  end

  assign extra_mask = mask_q & ~has;
  assign grown      = (CntW+1)'(rdata_q.size) + (CntW+1)'($countones(extra_mask));
  assign fit        = (grown <= (CntW+1)'(limit));
  assign last_entry = ((UsedW'(chk_q) + UsedW'(1)) >= used_q);
  assign full       = (int'(used_q) >= MaxPalettes);
  assign out_load   = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          if (reject_in)           state_d = SDone;
          else if (used_q == '0)   state_d = SPlace;
          else                     state_d = SScan;
        end
      end
      SScan: begin
        if (fit)             state_d = SDone;
        else if (last_entry) state_d = SPlace;
      end
      SPlace: state_d = SDone;
      SDone:  if (out_load) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Datapath control
  always_comb begin
    rd_addr   = '0;
    mem_we    = 1'b0;
    wr_new    = 1'b0;
    wr_addr   = chk_q;
    wr_row    = append_colors(rdata_q, rdata_q.size, extra_mask, tile_q);
    chk_d     = chk_q;
    used_d    = used_q;
    res_idx_d = res_idx_q;
    res_st_d  = res_st_q;
    unique case (state_q)
      SIdle: begin
        chk_d = '0;
        if (accept && reject_in) begin
          res_idx_d = '0;
          res_st_d  = StTooMany;
        end
      end
      SScan: begin
        rd_addr = chk_q + PalIdxW'(1);
        if (fit) begin
          mem_we    = 1'b1;
          res_idx_d = IdxOutW'(chk_q);
          res_st_d  = StMerged;
        end else begin
          chk_d = chk_q + PalIdxW'(1);
        end
      end
      SPlace: begin
        wr_addr = used_q[PalIdxW-1:0];
        wr_row  = append_colors(rdata_q, '0, mask_q, tile_q);
        if (full) begin
          res_idx_d = '0;
          res_st_d  = StFull;
        end else begin
          mem_we    = 1'b1;
          wr_new    = 1'b1;
          used_d    = used_q + UsedW'(1);
          res_idx_d = IdxOutW'(used_q);
          res_st_d  = StNew;
        end
      end
      SDone: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_row;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tile_q <= tile_in;
      mask_q <= mask_in;
      n_q    <= CntW'(n_in);
    end
    res_idx_q <= res_idx_d;
    res_st_q  <= res_st_d;
    if (state_q == SDone && out_load) begin
      out_idx_q <= res_idx_q;
      out_st_q  <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cfg_q       <= CfgReset;
      used_q      <= '0;
      chk_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      chk_q   <= chk_d;
      if (cfg_we_i) cfg_q <= cfg_data_i;
      if (state_q == SDone && out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i)            out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign palette_index_o = out_idx_q;
  assign status_o        = out_st_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(used_q) <= MaxPalettes)
    else $error("entry count beyond table size");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan) |-> (UsedW'(chk_q) < used_q))
    else $error("scan past last used entry");

  a_new_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_new |=> (used_q == $past(used_q) + UsedW'(1)))
    else $error("new entry did not bump entry count");

  a_merge_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !wr_new) |-> (int'(wr_row.size) <= int'(limit)))
    else $error("merged entry exceeds color limit");

  a_tile_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SPlace) |-> (n_q <= limit))
    else $error("oversized tile reached placement");

endmodule
